FILE: sv/ocr_pkg.sv
// Shared types and constants for the in-order completion reorder tracker.
// No dependencies; compile first.
package ocr_pkg;

    localparam int unsigned OCR_WINDOW       = 64;
    localparam int unsigned OCR_ORDINAL_BITS = 32;

    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned MEMBERS_W = 32;
    localparam int unsigned ORD_W     = 32;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned VALUE_W   = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_START_GROUP = 3'd0,
        FN_COMPLETE    = 3'd1,
        FN_NEXT        = 3'd2,
        FN_DONE        = 3'd3,
        FN_ERROR       = 3'd4,
        FN_QUERY_ERROR = 3'd5
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_GROUP_STARTED = 3'd0,
        ST_ACCEPTED      = 3'd1,
        ST_RELEASED      = 3'd2,
        ST_NOT_READY     = 3'd3,
        ST_FINISHED      = 3'd4,
        ST_OUT_OF_RANGE  = 3'd5,
        ST_DUPLICATE     = 3'd6,
        ST_AFTER_DONE    = 3'd7
    } t_status;

endpackage

FILE: sv/ocr_ifc.sv
// Valid/ready channel interfaces for the reorder tracker: command in, result out.
// Depends on ocr_pkg.
interface ocr_in_if;
    import ocr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [MEMBERS_W-1:0] group_members;
    logic [ORD_W-1:0]     ordinal;

    modport source(output valid, func, group_members, ordinal, input ready);
    modport sink(input valid, func, group_members, ordinal, output ready);
endinterface

interface ocr_out_if;
    import ocr_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic                error_flag;

    modport source(output valid, status, value, error_flag, input ready);
    modport sink(input valid, status, value, error_flag, output ready);
endinterface

FILE: sv/in_order_completion_reorder.sv
// Channel  | Dir | Payload                         | Handshake
// i_in     | in  | func, group_members, ordinal    | valid/ready
// o_out    | out | status, value, error_flag       | valid/ready
//
// One item per cycle sustained while results are taken; a taken item passes
// through the input register, then the result register, where its result is
// offered. All work of one item is done between those two registers, so
// an item sees the state left by the previous one. Reset is synchronous and
// clears every tracker counter and flag and the whole completion bitmap
// at once (flip-flops, no clearing sweep). A stalled result holds the input
// register; one more item is still taken while that register is empty.
// Depends on ocr_pkg and ocr_ifc.
module in_order_completion_reorder #(
    parameter int unsigned WINDOW       = ocr_pkg::OCR_WINDOW,
    parameter int unsigned ORDINAL_BITS = ocr_pkg::OCR_ORDINAL_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ocr_in_if.sink     i_in,
    ocr_out_if.source  o_out
);
    import ocr_pkg::*;

    localparam int unsigned SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned PW = $clog2(WINDOW + 1);
    localparam int unsigned WB = SW + 1;
    localparam int unsigned CW = (ORDINAL_BITS > WB) ? ORDINAL_BITS : WB;

    typedef logic [ORDINAL_BITS-1:0] t_ord;
    typedef logic [SW-1:0]           t_slot;
    typedef logic [PW-1:0]           t_pend;

    // input register
    logic              r_s1_valid;
    logic [FUNC_W-1:0] r_s1_func;
    t_ord              r_s1_members;
    t_ord              r_s1_ord;

    // tracker state
    t_ord              r_next_base, n_next_base;
    t_ord              r_grp_low,   n_grp_low;
    t_ord              r_grp_high,  n_grp_high;
    t_ord              r_consumer,  n_consumer;
    logic [WINDOW-1:0] r_map,       n_map;
    t_slot             r_head,      n_head;
    t_pend             r_pending,   n_pending;
    logic              r_done,      n_done;
    logic              r_error,     n_error;

    // result register
    logic               r_out_valid;
    t_status            r_out_status, n_status;
    logic [VALUE_W-1:0] r_out_value,  n_value;
    logic               r_out_error;

    logic    s1_fire;
    t_ord    span, off, ahead;
    logic    [WB-1:0] slot_sum;
    t_slot   slot;
    t_slot   head_inc;

    assign s1_fire    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.value      = r_out_value;
    assign o_out.error_flag = r_out_error;

    assign span  = r_grp_high - r_grp_low;
    assign off   = r_s1_ord - r_grp_low;
    assign ahead = r_s1_ord - r_consumer;

    // ring slot of the completed ordinal; only used when ahead < WINDOW
    assign slot_sum = {1'b0, r_head} + {1'b0, SW'(ahead)};
    assign slot     = (slot_sum >= WB'(WINDOW)) ? SW'(slot_sum - WB'(WINDOW))
                                                : SW'(slot_sum);
    assign head_inc = (r_head == SW'(WINDOW - 1)) ? '0 : r_head + SW'(1);

    always_comb begin
        n_next_base = r_next_base;
        n_grp_low   = r_grp_low;
        n_grp_high  = r_grp_high;
        n_consumer  = r_consumer;
        n_map       = r_map;
        n_head      = r_head;
        n_pending   = r_pending;
        n_done      = r_done;
        n_error     = r_error;
        n_status    = ST_OUT_OF_RANGE;
        n_value     = '0;
        case (r_s1_func)
            FN_START_GROUP: begin
                n_value     = VALUE_W'(r_next_base);
                n_grp_low   = r_next_base;
                n_grp_high  = r_next_base + r_s1_members;
                n_next_base = r_next_base + r_s1_members;
                n_status    = ST_GROUP_STARTED;
            end
            FN_COMPLETE: begin
                if (r_done) begin
                    n_status = ST_AFTER_DONE;
                end else if (off >= span) begin
                    n_status = ST_OUT_OF_RANGE;
                end else if (ahead[ORDINAL_BITS-1]) begin
                    // behind the head: already released
                    n_status = ST_DUPLICATE;
                end else if (CW'(ahead) >= CW'(WINDOW)) begin
                    n_status = ST_OUT_OF_RANGE;
                end else if (r_map[slot]) begin
                    n_status = ST_DUPLICATE;
                end else begin
                    n_map[slot] = 1'b1;
                    n_pending   = r_pending + t_pend'(1);
                    n_status    = ST_ACCEPTED;
                end
            end
            FN_NEXT: begin
                if (r_error || (r_done && r_pending == '0)) begin
                    n_status = ST_FINISHED;
                end else if (!r_map[r_head]) begin
                    n_status = ST_NOT_READY;
                end else begin
                    n_map[r_head] = 1'b0;
                    n_value       = VALUE_W'(r_consumer);
                    n_consumer    = r_consumer + t_ord'(1);
                    n_head        = head_inc;
                    n_pending     = r_pending - t_pend'(1);
                    n_status      = ST_RELEASED;
                end
            end
            FN_DONE: begin
                n_done   = 1'b1;
                n_status = ST_ACCEPTED;
            end
            FN_ERROR: begin
                n_error  = 1'b1;
                n_status = ST_ACCEPTED;
            end
            FN_QUERY_ERROR: begin
                n_status = ST_ACCEPTED;
            end
            default: begin
                n_status = ST_OUT_OF_RANGE;
            end
        endcase
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_next_base <= '0;
            r_grp_low   <= '0;
            r_grp_high  <= '0;
            r_consumer  <= '0;
            r_map       <= '0;
            r_head      <= '0;
            r_pending   <= '0;
            r_done      <= 1'b0;
            r_error     <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_next_base <= n_next_base;
                r_grp_low   <= n_grp_low;
                r_grp_high  <= n_grp_high;
                r_consumer  <= n_consumer;
                r_map       <= n_map;
                r_head      <= n_head;
                r_pending   <= n_pending;
                r_done      <= n_done;
                r_error     <= n_error;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_func    <= i_in.func;
            r_s1_members <= ORDINAL_BITS'(i_in.group_members);
            r_s1_ord     <= ORDINAL_BITS'(i_in.ordinal);
        end
        if (s1_fire) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
            r_out_error  <= n_error;
        end
    end

    // pending count tracks the number of marked bits in the window
    a_pending_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == PW'($countones(r_map)))
        else $error("pending count disagrees with completion bitmap");

    a_release_advances_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && n_status == ST_RELEASED |=> r_consumer == $past(r_consumer) + t_ord'(1))
        else $error("release did not advance the head ordinal");

    a_empty_result_takes_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while result register is empty");

endmodule
